/* sv/integer_to_padded_ascii_core_assert.svh */
// assertion macros for the integer to padded ascii core
`ifndef INTEGER_TO_PADDED_ASCII_CORE_ASSERT_SVH
`define INTEGER_TO_PADDED_ASCII_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define ITPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, disabled in reset
`define ITPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/itpa_pkg.sv */
// shared types, constants and helpers of the integer to padded ascii core
package itpa_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int VALUE_W        = 16;
    localparam int FUNC_W         = 3;
    localparam int WIDTH_W        = 5;
    localparam int CHAR_W         = 7;
    localparam int MAX_CHARS      = 31;
    localparam int CNT_W          = 5;

    localparam logic [FUNC_W-1:0] FUNC_SDEC    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_UDEC_SP = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_UDEC_ZP = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_HEX     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_BIN     = 3'd4;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 7'h61;

    typedef struct packed {
        logic load;
        logic conv;
        logic bcd_load;
        logic strip;
        logic emit_pad;
        logic emit_sign;
        logic emit_digit;
    } itpa_cmd_t;

    typedef struct packed {
        logic is_dec;
        logic conv_done;
        logic strip_done;
        logic pad_needed;
        logic neg;
        logic dig_last;
        logic cap;
        logic out_free;
    } itpa_sts_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        if (d < 4'd10)
            return CHAR_ZERO + {3'b000, d};
        else
            return CHAR_LA + {3'b000, d} - 7'd10;
    endfunction

endpackage

/* sv/itpa_ctrl.sv */
// controller state machine: conversion, leading zero strip and character emission
module itpa_ctrl
    import itpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  itpa_sts_t sts,
    output itpa_cmd_t cmd
);

    `include "integer_to_padded_ascii_core_assert.svh"

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CONV  = 6'b000010,
        S_STRIP = 6'b000100,
        S_PAD   = 6'b001000,
        S_SIGN  = 6'b010000,
        S_DIGIT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (!sts.is_dec)
                    state_next = S_STRIP;
                else if (sts.conv_done)
                begin
                    cmd.bcd_load = 1'b1;
                    state_next   = S_STRIP;
                end
                else
                    cmd.conv = 1'b1;
            end
            S_STRIP:
            begin
                if (sts.strip_done)
                    state_next = S_PAD;
                else
                    cmd.strip = 1'b1;
            end
            S_PAD:
            begin
                if (!sts.pad_needed)
                    state_next = sts.neg ? S_SIGN : S_DIGIT;
                else if (sts.out_free)
                begin
                    cmd.emit_pad = 1'b1;
                    if (sts.cap)
                        state_next = S_IDLE;
                end
            end
            S_SIGN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = sts.cap ? S_IDLE : S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (sts.dig_last || sts.cap)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ITPA_ASSERT_IMP(a_emit_needs_room,
        cmd.emit_pad || cmd.emit_sign || cmd.emit_digit, sts.out_free,
        "character emitted while output register is full")
    `ITPA_ASSERT_NXT(a_accept_starts_conv, in_valid && in_ready, state_reg == S_CONV,
        "accepted transfer did not start conversion")

endmodule

/* sv/itpa_datapath.sv */
// datapath: operand capture, binary to bcd, digit slots, counters and output register
module itpa_datapath
    import itpa_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  itpa_cmd_t           cmd,
    output itpa_sts_t           sts,
    input  logic [FUNC_W-1:0]   func,
    input  logic [VALUE_W-1:0]  value,
    input  logic [WIDTH_W-1:0]  field_width,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CHAR_W-1:0]   character,
    output logic                last
);

    `include "integer_to_padded_ascii_core_assert.svh"

    localparam int EXT_W  = (VALUE_BITS > VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int DEC_D  = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int HEX_D  = (VALUE_BITS + 3) / 4;
    localparam int ND_W   = $clog2(VALUE_BITS + 1);
    localparam int BCNT_W = $clog2(VALUE_BITS + 1);
    localparam int CMP_W  = ND_W + WIDTH_W;

    typedef logic [VALUE_BITS-1:0][3:0] slots_t;

    logic                    is_dec_reg, is_dec_next;
    logic                    zpad_reg, zpad_next;
    logic                    neg_reg, neg_next;
    logic [WIDTH_W-1:0]      wrem_reg, wrem_next;
    logic [VALUE_BITS-1:0]   bin_reg, bin_next;
    logic [DEC_D*4-1:0]      bcd_reg, bcd_next;
    logic [BCNT_W-1:0]       bcnt_reg, bcnt_next;
    slots_t                  slot_reg, slot_next;
    logic [ND_W-1:0]         nd_reg, nd_next;
    logic [CNT_W-1:0]        emitted_reg, emitted_next;
    logic                    out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]       char_reg, char_next;
    logic                    last_reg, last_next;

    logic [EXT_W-1:0]        value_ext;
    logic [VALUE_BITS-1:0]   v_in;
    logic [VALUE_BITS-1:0]   mag;
    logic                    in_neg;
    logic                    in_dec;
    logic                    in_hex;
    logic                    in_zpad;
    logic [HEX_D*4-1:0]      hex_vec;
    slots_t                  hex_slots;
    slots_t                  bin_slots;
    slots_t                  dec_slots;
    logic [DEC_D*4-1:0]      bcd_adj;
    logic                    cap;

    assign value_ext = EXT_W'(value);
    assign v_in      = value_ext[VALUE_BITS-1:0];

    always_comb
    begin
        in_dec  = 1'b1;
        in_hex  = 1'b0;
        in_zpad = 1'b0;
        in_neg  = 1'b0;
        case (func)
            FUNC_SDEC:    in_neg  = v_in[VALUE_BITS-1];
            FUNC_UDEC_ZP: in_zpad = 1'b1;
            FUNC_HEX:     begin in_dec = 1'b0; in_hex = 1'b1; end
            FUNC_BIN:     begin in_dec = 1'b0; in_zpad = 1'b1; end
            default:      in_dec  = 1'b1;
        endcase
    end

    assign mag     = in_neg ? (~v_in + 1'b1) : v_in;
    assign hex_vec = (HEX_D*4)'(mag);

    always_comb
    begin
        hex_slots = '0;
        bin_slots = '0;
        dec_slots = '0;
        for (int k = 0; k < HEX_D; k++)
            hex_slots[VALUE_BITS-HEX_D+k] = hex_vec[4*k +: 4];
        for (int j = 0; j < VALUE_BITS; j++)
            bin_slots[j] = {3'b000, mag[j]};
        for (int k = 0; k < DEC_D; k++)
            dec_slots[VALUE_BITS-DEC_D+k] = bcd_reg[4*k +: 4];
        for (int k = 0; k < DEC_D; k++)
            bcd_adj[4*k +: 4] = (bcd_reg[4*k +: 4] >= 4'd5) ?
                                (bcd_reg[4*k +: 4] + 4'd3) : bcd_reg[4*k +: 4];
    end

    assign cap = (emitted_reg == CNT_W'(MAX_CHARS - 1));

    always_comb
    begin
        is_dec_next    = is_dec_reg;
        zpad_next      = zpad_reg;
        neg_next       = neg_reg;
        wrem_next      = wrem_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        bcnt_next      = bcnt_reg;
        slot_next      = slot_reg;
        nd_next        = nd_reg;
        emitted_next   = emitted_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.load)
        begin
            is_dec_next  = in_dec;
            zpad_next    = in_zpad;
            neg_next     = in_neg;
            wrem_next    = field_width;
            bin_next     = mag;
            bcd_next     = '0;
            bcnt_next    = BCNT_W'(VALUE_BITS);
            emitted_next = '0;
            slot_next    = in_hex ? hex_slots : bin_slots;
            nd_next      = in_hex ? ND_W'(HEX_D) : ND_W'(VALUE_BITS);
        end

        if (cmd.conv)
        begin
            bcd_next  = {bcd_adj[DEC_D*4-2:0], bin_reg[VALUE_BITS-1]};
            bin_next  = {bin_reg[VALUE_BITS-2:0], 1'b0};
            bcnt_next = bcnt_reg - 1'b1;
        end

        if (cmd.bcd_load)
        begin
            slot_next = dec_slots;
            nd_next   = ND_W'(DEC_D);
        end

        if (cmd.strip || cmd.emit_digit)
        begin
            slot_next = {slot_reg[VALUE_BITS-2:0], 4'h0};
            nd_next   = nd_reg - 1'b1;
        end

        if (cmd.emit_pad)
            wrem_next = wrem_reg - 1'b1;

        if (cmd.emit_pad || cmd.emit_sign || cmd.emit_digit)
        begin
            out_valid_next = 1'b1;
            emitted_next   = emitted_reg + 1'b1;
        end

        if (cmd.emit_pad)
        begin
            char_next = zpad_reg ? CHAR_ZERO : CHAR_SPACE;
            last_next = cap;
        end
        else if (cmd.emit_sign)
        begin
            char_next = CHAR_MINUS;
            last_next = cap;
        end
        else if (cmd.emit_digit)
        begin
            char_next = digit_char(slot_reg[VALUE_BITS-1]);
            last_next = (nd_reg == ND_W'(1)) || cap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            emitted_reg   <= '0;
            nd_reg        <= '0;
            bcnt_reg      <= '0;
            is_dec_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            emitted_reg   <= emitted_next;
            nd_reg        <= nd_next;
            bcnt_reg      <= bcnt_next;
            is_dec_reg    <= is_dec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zpad_reg <= zpad_next;
        neg_reg  <= neg_next;
        wrem_reg <= wrem_next;
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        slot_reg <= slot_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign sts.is_dec     = is_dec_reg;
    assign sts.conv_done  = (bcnt_reg == '0);
    assign sts.strip_done = (nd_reg == ND_W'(1)) || (slot_reg[VALUE_BITS-1] != 4'h0);
    assign sts.pad_needed = CMP_W'(wrem_reg) > (CMP_W'(nd_reg) + CMP_W'(neg_reg));
    assign sts.neg        = neg_reg;
    assign sts.dig_last   = (nd_reg == ND_W'(1));
    assign sts.cap        = cap;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    `ITPA_ASSERT_IMP(a_digit_left, cmd.emit_digit || cmd.strip, nd_reg != '0,
        "digit slot consumed with no digit left")
    `ITPA_ASSERT_IMP(a_conv_only_dec, cmd.conv, is_dec_reg && (bcnt_reg != '0),
        "bcd step issued outside a decimal conversion")

endmodule

/* sv/integer_to_padded_ascii_core.sv */
// top level of the integer to padded ascii core: controller plus datapath
// sequence: after the input transfer the operand is loaded, decimal values then go through
// the binary to bcd steps, leading zero digits are stripped, and the pads, the sign if negative and the digits follow
// throughput: one character per cycle while out_ready holds, none on the step out of the pads;
// a new item is accepted only once the last character of the current one has been emitted
// reset: rst_n clears the state machine, counters and output valid; the data registers are not reset
module integer_to_padded_ascii_core
    import itpa_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FUNC_W-1:0]  func,
    input  logic [VALUE_W-1:0] value,
    input  logic [WIDTH_W-1:0] field_width,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAR_W-1:0]  character,
    output logic               last
);

    itpa_cmd_t cmd;
    itpa_sts_t sts;

    itpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    itpa_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .func        (func),
        .value       (value),
        .field_width (field_width),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .character   (character),
        .last        (last)
    );

endmodule
